// ----- hdl/fecu_pkg.sv -----
`default_nettype none

package fecu_pkg;

	// line framing codes
	localparam logic [7:0] START_BYTE = 8'hCA;
	localparam logic [7:0] ESC_BYTE = 8'hCB;
	localparam logic [7:0] ESC_START_CODE = 8'h00;
	localparam logic [7:0] ESC_ESC_CODE = 8'h01;

	// reflected CRC-16
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] CRC_INIT = 16'h173F;

	// request kinds
	localparam logic KIND_HEADER = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	// one decoded request handed from front to back
	typedef struct packed {
		logic        kind;
		logic [7:0]  command;
		logic [15:0] payload_length;
		logic [7:0]  data_byte;
		logic        close;
	} job_t;

	// one line byte handed to the output queue
	typedef struct packed {
		logic [7:0] line_byte;
		logic       frame_end;
		logic       last;
	} out_t;

	// back-end byte sequencer steps
	typedef enum logic [8:0] {
		S_FIRST = 9'b000000001,
		S_ADR2  = 9'b000000010,
		S_ADR1  = 9'b000000100,
		S_ADR0  = 9'b000001000,
		S_LENH  = 9'b000010000,
		S_LENL  = 9'b000100000,
		S_CMD   = 9'b001000000,
		S_CRCH  = 9'b010000000,
		S_CRCL  = 9'b100000000
	} step_t;

	// one byte through the CRC, LSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/fecu_fifo.sv -----
`default_nettype none

module fecu_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full = (cnt_q == FULL_CNT);
	assign empty = (cnt_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/fecu_front.sv -----
`default_nettype none

module fecu_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic          kind,
	input  wire logic [7:0]    command,
	input  wire logic [15:0]   payload_length,
	input  wire logic [7:0]    data_byte,
	input  wire logic          jq_full,
	output logic               jq_push,
	output fecu_pkg::job_t     jq_job
);
	import fecu_pkg::*;

	logic        frame_open_q;
	logic [15:0] remain_q;
	logic        accept;
	logic        keep;

	// classify: headers always pass, payload only inside an open frame
	always_comb begin
		accept = push && !jq_full;
		keep = (kind == KIND_HEADER) || frame_open_q;
		jq_push = accept && keep;
		jq_job.kind = kind;
		jq_job.command = command;
		jq_job.payload_length = payload_length;
		jq_job.data_byte = data_byte;
		jq_job.close = (kind == KIND_HEADER) ? (payload_length == 16'd0)
			: (remain_q == 16'd1);
	end

	// frame tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
			remain_q <= '0;
		end else if (accept) begin
			if (kind == KIND_HEADER) begin
				frame_open_q <= (payload_length != 16'd0);
				remain_q <= payload_length;
			end else if (frame_open_q) begin
				remain_q <= remain_q - 16'd1;
				if (remain_q == 16'd1) begin
					frame_open_q <= 1'b0;
				end
			end
		end
	end

	// an open frame always has bytes left to take
	a_open_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		frame_open_q |-> (remain_q != 16'd0))
		else $error("open frame with no bytes remaining");

endmodule

`default_nettype wire

// ----- hdl/fecu_back.sv -----
`default_nettype none

module fecu_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [23:0]     device_address,
	input  wire logic            head_valid,
	input  wire fecu_pkg::job_t  head,
	output logic                 head_pop,
	input  wire logic            out_room,
	output logic                 out_push,
	output fecu_pkg::out_t       out_item
);
	import fecu_pkg::*;

	step_t       state_q;
	step_t       state_d;
	logic [15:0] crc_q;
	logic [7:0]  crc_lo_q;
	logic        esc_q;
	logic [7:0]  esc_byte_q;
	logic        esc_end_q;
	logic        esc_last_q;

	logic        go;
	logic        raw_start;
	logic [7:0]  cooked;
	logic        fin;
	logic        fend;
	logic        needs_esc;
	logic [7:0]  esc_code;

	// pick the cooked byte for this step
	always_comb begin
		go = !esc_q && head_valid && out_room;
		raw_start = 1'b0;
		cooked = head.data_byte;
		fin = 1'b0;
		fend = 1'b0;
		state_d = state_q;
		case (state_q)
			S_FIRST: begin
				if (head.kind == KIND_HEADER) begin
					raw_start = 1'b1;
					state_d = S_ADR2;
				end else begin
					cooked = head.data_byte;
					fin = !head.close;
					state_d = head.close ? S_CRCH : S_FIRST;
				end
			end
			S_ADR2: begin
				cooked = device_address[23:16];
				state_d = S_ADR1;
			end
			S_ADR1: begin
				cooked = device_address[15:8];
				state_d = S_ADR0;
			end
			S_ADR0: begin
				cooked = device_address[7:0];
				state_d = S_LENH;
			end
			S_LENH: begin
				cooked = head.payload_length[15:8];
				state_d = S_LENL;
			end
			S_LENL: begin
				cooked = head.payload_length[7:0];
				state_d = S_CMD;
			end
			S_CMD: begin
				cooked = head.command;
				fin = !head.close;
				state_d = head.close ? S_CRCH : S_FIRST;
			end
			S_CRCH: begin
				cooked = crc_q[15:8];
				state_d = S_CRCL;
			end
			S_CRCL: begin
				cooked = crc_lo_q;
				fin = 1'b1;
				fend = 1'b1;
				state_d = S_FIRST;
			end
			default: begin
				state_d = S_FIRST;
			end
		endcase
		needs_esc = !raw_start && ((cooked == START_BYTE) || (cooked == ESC_BYTE));
		esc_code = (cooked == START_BYTE) ? ESC_START_CODE : ESC_ESC_CODE;
	end

	// line byte out: pending escape code first, else the step's byte
	always_comb begin
		out_push = 1'b0;
		out_item.line_byte = cooked;
		out_item.frame_end = fend;
		out_item.last = fin;
		if (esc_q) begin
			out_push = out_room;
			out_item.line_byte = esc_byte_q;
			out_item.frame_end = esc_end_q;
			out_item.last = esc_last_q;
		end else if (go) begin
			out_push = 1'b1;
			if (raw_start) begin
				out_item.line_byte = START_BYTE;
			end else if (needs_esc) begin
				out_item.line_byte = ESC_BYTE;
				out_item.frame_end = 1'b0;
				out_item.last = 1'b0;
			end
		end
		head_pop = go && fin;
	end

	// sequencer, CRC and escape state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_FIRST;
			esc_q <= 1'b0;
			crc_q <= CRC_INIT;
		end else if (esc_q) begin
			if (out_room) begin
				esc_q <= 1'b0;
			end
		end else if (go) begin
			state_q <= state_d;
			if (raw_start) begin
				crc_q <= CRC_INIT;
			end else begin
				crc_q <= crc_byte(crc_q, cooked);
				esc_q <= needs_esc;
			end
		end
	end

	// escape payload and saved CRC low byte
	always_ff @(posedge clk) begin
		if (go) begin
			esc_byte_q <= esc_code;
			esc_end_q <= fend;
			esc_last_q <= fin;
			if (state_q == S_CRCH) begin
				crc_lo_q <= crc_q[7:0];
			end
		end
	end

	a_pop_emits: assert property (@(posedge clk) disable iff (!arst_n)
		head_pop |-> out_push)
		else $error("request retired without a line byte");

	a_esc_code: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q |-> (esc_byte_q[7:1] == 7'd0))
		else $error("bad escape code pending");

	a_crcl_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CRCL) && ($past(state_q) != S_CRCL) |-> ($past(state_q) == S_CRCH))
		else $error("CRC low byte not preceded by CRC high byte");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_push && out_item.frame_end |-> out_item.last)
		else $error("frame end not marked last");

endmodule

`default_nettype wire

// ----- hdl/escaped_crc_frame_encoder_unit.sv -----
// Escaped CRC-16 frame encoder.
// Input channel (push/full): one request per accepted edge. kind 0 is a frame
// header (command, payload_length), kind 1 a payload byte (data_byte).
// Output channel (empty/pop): one raw line byte per result, with frame_end on
// the final CRC byte and last on the final byte caused by a request.
// cfg_write/cfg_data load the 24-bit device address; write only while idle.
// The front tracks the open frame, drops payload bytes outside a frame and
// queues requests; the back sequencer emits one line byte per cycle while it
// has a request and the output queue has room. The first line byte passes
// through the request queue and the output queue before it reaches the ports.
// A payload byte gives one line byte, two when escaped; the byte that closes
// a frame adds two to four line bytes for the CRC. A header gives seven to
// thirteen line bytes, plus the CRC when its length is zero.
// Reset clears the queues and frame state, loads CRC_INIT; the address is 0.
// When the receiver stalls the output queue fills, the back waits, and full
// rises once the request queue has filled.
`default_nettype none

module escaped_crc_frame_encoder_unit #(
	parameter int JOBQ_DEPTH = 4,
	parameter int OUTQ_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic        kind,
	input  wire logic [7:0]  command,
	input  wire logic [15:0] payload_length,
	input  wire logic [7:0]  data_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       line_byte,
	output logic             frame_end,
	output logic             last,
	input  wire logic        cfg_write,
	input  wire logic [23:0] cfg_data
);
	import fecu_pkg::*;

	logic [23:0] device_address_q;
	logic        jq_push;
	logic        jq_full;
	logic        jq_empty;
	logic        jq_pop;
	job_t        jq_in;
	job_t        jq_head;
	logic        oq_push;
	logic        oq_full;
	out_t        oq_in;
	out_t        oq_head;

	// address register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= '0;
		end else if (cfg_write) begin
			device_address_q <= cfg_data;
		end
	end

	assign full = jq_full;

	fecu_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.kind          (kind),
		.command       (command),
		.payload_length(payload_length),
		.data_byte     (data_byte),
		.jq_full       (jq_full),
		.jq_push       (jq_push),
		.jq_job        (jq_in)
	);

	fecu_fifo #(
		.WIDTH($bits(job_t)),
		.DEPTH(JOBQ_DEPTH)
	) u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (jq_push),
		.wr_data(jq_in),
		.full   (jq_full),
		.rd_en  (jq_pop),
		.rd_data(jq_head),
		.empty  (jq_empty)
	);

	fecu_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.device_address(device_address_q),
		.head_valid    (!jq_empty),
		.head          (jq_head),
		.head_pop      (jq_pop),
		.out_room      (!oq_full),
		.out_push      (oq_push),
		.out_item      (oq_in)
	);

	fecu_fifo #(
		.WIDTH($bits(out_t)),
		.DEPTH(OUTQ_DEPTH)
	) u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (oq_push),
		.wr_data(oq_in),
		.full   (oq_full),
		.rd_en  (pop),
		.rd_data(oq_head),
		.empty  (empty)
	);

	assign line_byte = oq_head.line_byte;
	assign frame_end = oq_head.frame_end;
	assign last = oq_head.last;

endmodule

`default_nettype wire
